/* rtl/assert_macros.svh */
// Assertion macros used by the port-level checker.
// Each macro clocks on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression holds at every clock edge.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/jdd_pkg.sv */
// Package for the joystick direction debouncer: direction codes,
// register indexes, reset values and fixed field widths. No dependencies.
`default_nettype none

package jdd_pkg;

    typedef enum logic [2:0] {
        DIR_CENTER = 3'd0,
        DIR_UP     = 3'd1,
        DIR_DOWN   = 3'd2,
        DIR_LEFT   = 3'd3,
        DIR_RIGHT  = 3'd4
    } dir_t;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int TIME_W     = 32;
    localparam int SETTLE_W   = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_VALUE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALUE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_VALUE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_BAND    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FLIP_X       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FLIP_Y       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_MS    = 3'd6;

    // Reset values before truncation to the sample width.
    localparam logic [15:0] RST_MIN_VALUE    = 16'd1200;
    localparam logic [15:0] RST_MAX_VALUE    = 16'd4095;
    localparam logic [15:0] RST_CENTER_VALUE = 16'd2559;
    localparam logic [15:0] RST_DEAD_BAND    = 16'd300;
    localparam logic [SETTLE_W-1:0] RST_SETTLE_MS = 16'd50;

endpackage

`default_nettype wire

/* rtl/jdd_decode.sv */
// Direction decode: axis mirroring, deltas from centre, deadzone and
// dominant-axis selection. Pure combinational logic; uses jdd_pkg.
`default_nettype none

module jdd_decode
    import jdd_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
) (
    input  wire logic [SAMPLE_BITS-1:0] x_sample,
    input  wire logic [SAMPLE_BITS-1:0] y_sample,
    input  wire logic [SAMPLE_BITS-1:0] min_value,
    input  wire logic [SAMPLE_BITS-1:0] max_value,
    input  wire logic [SAMPLE_BITS-1:0] center_value,
    input  wire logic [SAMPLE_BITS-1:0] dead_band,
    input  wire logic                   flip_x,
    input  wire logic                   flip_y,
    output dir_t                        direction
);

    // Mirrored values span -(2^W-1)..2*(2^W-1); deltas span -2*(2^W-1)..2*(2^W-1).
    localparam int VW = SAMPLE_BITS + 3;

    logic signed [VW-1:0] x_val;
    logic signed [VW-1:0] y_val;
    logic signed [VW-1:0] dx;
    logic signed [VW-1:0] dy;
    logic        [VW-1:0] ax;
    logic        [VW-1:0] ay;
    logic        [VW-1:0] db;
    logic        [VW-1:0] span;

    assign span = {3'b000, max_value} + {3'b000, min_value};

    assign x_val = flip_x ? $signed(span - {3'b000, x_sample})
                          : $signed({3'b000, x_sample});
    assign y_val = flip_y ? $signed(span - {3'b000, y_sample})
                          : $signed({3'b000, y_sample});

    assign dx = x_val - $signed({3'b000, center_value});
    assign dy = y_val - $signed({3'b000, center_value});

    assign ax = dx[VW-1] ? VW'(-dx) : VW'(dx);
    assign ay = dy[VW-1] ? VW'(-dy) : VW'(dy);
    assign db = {3'b000, dead_band};

    always_comb
    begin
        if ((ax < db) && (ay < db))
        begin
            direction = DIR_CENTER;
        end
        else if (ax > ay)
        begin
            direction = (!dx[VW-1] && (dx != '0)) ? DIR_RIGHT : DIR_LEFT;
        end
        else
        begin
            direction = (!dy[VW-1] && (dy != '0)) ? DIR_UP : DIR_DOWN;
        end
    end

endmodule

`default_nettype wire

/* rtl/joystick_direction_debouncer_top.sv */
// Top level of the joystick direction debouncer: input register, decode,
// debounce state and result register. Uses jdd_pkg and jdd_decode.
`default_nettype none

// Takes one joystick sample per transaction and returns exactly one result
// per transaction, in order. A transaction is captured into an input
// register, decoded and debounced there and written into a result register
// once that register has space; the outputs are driven from the result
// register. One transaction per clock is sustained while out_ready stays
// high: the input register hands its transaction on whenever the result
// register is empty or being emptied, and the debounce state (held direction,
// held button, change timestamps) updates on that same edge, so each
// transaction sees the state left by the one before it. Configuration
// registers are written through cfg_we, cfg_index and cfg_data; the user must
// write them only while no transaction is in flight, which the block does not
// enforce. Writes to an index outside the register list are dropped.
module joystick_direction_debouncer_top
    import jdd_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // configuration
    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    // input channel
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [SAMPLE_BITS-1:0] x_sample,
    input  wire logic [SAMPLE_BITS-1:0] y_sample,
    input  wire logic                   button_down,
    input  wire logic [TIME_W-1:0]      now_ms,
    // result channel
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [2:0]                  direction,
    output logic                        direction_changed,
    output logic                        press_event,
    output logic                        button_level
);

    localparam logic [SAMPLE_BITS-1:0] MIN_RST    = RST_MIN_VALUE[SAMPLE_BITS-1:0];
    localparam logic [SAMPLE_BITS-1:0] MAX_RST    = RST_MAX_VALUE[SAMPLE_BITS-1:0];
    localparam logic [SAMPLE_BITS-1:0] CENTER_RST = RST_CENTER_VALUE[SAMPLE_BITS-1:0];
    localparam logic [SAMPLE_BITS-1:0] DB_RST     = RST_DEAD_BAND[SAMPLE_BITS-1:0];

    // Configuration registers
    logic [SAMPLE_BITS-1:0] min_value_reg;
    logic [SAMPLE_BITS-1:0] max_value_reg;
    logic [SAMPLE_BITS-1:0] center_value_reg;
    logic [SAMPLE_BITS-1:0] dead_band_reg;
    logic                   flip_x_reg;
    logic                   flip_y_reg;
    logic [SETTLE_W-1:0]    settle_ms_reg;

    // Input register
    logic                   s1_valid_reg;
    logic [SAMPLE_BITS-1:0] s1_x_reg;
    logic [SAMPLE_BITS-1:0] s1_y_reg;
    logic                   s1_button_reg;
    logic [TIME_W-1:0]      s1_now_reg;

    // Debounce state
    logic                   held_button_reg;
    logic                   held_button_next;
    logic [TIME_W-1:0]      button_time_reg;
    logic [TIME_W-1:0]      button_time_next;
    dir_t                   held_dir_reg;
    dir_t                   held_dir_next;
    logic [TIME_W-1:0]      dir_time_reg;
    logic [TIME_W-1:0]      dir_time_next;

    // Result register
    logic                   out_valid_reg;
    dir_t                   out_dir_reg;
    logic                   out_changed_reg;
    logic                   out_press_reg;
    logic                   out_level_reg;

    logic                   in_fire;
    logic                   s1_advance;
    logic                   out_space;
    dir_t                   decoded_dir;
    logic [TIME_W-1:0]      button_elapsed;
    logic [TIME_W-1:0]      dir_elapsed;
    logic                   button_take;
    logic                   dir_take;

    // Result register frees up when empty or when its transaction leaves.
    assign out_space  = !out_valid_reg || out_ready;
    assign s1_advance = s1_valid_reg && out_space;
    assign in_ready   = !s1_valid_reg || out_space;
    assign in_fire    = in_valid && in_ready;

    // Configuration writes; unknown indexes fall through and are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_value_reg    <= MIN_RST;
            max_value_reg    <= MAX_RST;
            center_value_reg <= CENTER_RST;
            dead_band_reg    <= DB_RST;
            flip_x_reg       <= 1'b0;
            flip_y_reg       <= 1'b0;
            settle_ms_reg    <= RST_SETTLE_MS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MIN_VALUE:    min_value_reg    <= cfg_data[SAMPLE_BITS-1:0];
                CFG_MAX_VALUE:    max_value_reg    <= cfg_data[SAMPLE_BITS-1:0];
                CFG_CENTER_VALUE: center_value_reg <= cfg_data[SAMPLE_BITS-1:0];
                CFG_DEAD_BAND:    dead_band_reg    <= cfg_data[SAMPLE_BITS-1:0];
                CFG_FLIP_X:       flip_x_reg       <= cfg_data[0];
                CFG_FLIP_Y:       flip_y_reg       <= cfg_data[0];
                CFG_SETTLE_MS:    settle_ms_reg    <= cfg_data[SETTLE_W-1:0];
                default:          ;
            endcase
        end
    end

    // Input register: valid is control, the payload just follows a capture.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_x_reg      <= x_sample;
            s1_y_reg      <= y_sample;
            s1_button_reg <= button_down;
            s1_now_reg    <= now_ms;
        end
    end

    jdd_decode #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_decode (
        .x_sample     (s1_x_reg),
        .y_sample     (s1_y_reg),
        .min_value    (min_value_reg),
        .max_value    (max_value_reg),
        .center_value (center_value_reg),
        .dead_band    (dead_band_reg),
        .flip_x       (flip_x_reg),
        .flip_y       (flip_y_reg),
        .direction    (decoded_dir)
    );

    // Wrapping elapsed time; a change needs strictly more than settle_ms.
    assign button_elapsed = s1_now_reg - button_time_reg;
    assign dir_elapsed    = s1_now_reg - dir_time_reg;

    assign button_take = (s1_button_reg != held_button_reg)
                       && (button_elapsed > {{(TIME_W-SETTLE_W){1'b0}}, settle_ms_reg});
    assign dir_take    = (decoded_dir != held_dir_reg)
                       && (dir_elapsed > {{(TIME_W-SETTLE_W){1'b0}}, settle_ms_reg});

    always_comb
    begin
        held_button_next = held_button_reg;
        button_time_next = button_time_reg;
        held_dir_next    = held_dir_reg;
        dir_time_next    = dir_time_reg;
        if (button_take)
        begin
            held_button_next = s1_button_reg;
            button_time_next = s1_now_reg;
        end
        if (dir_take)
        begin
            held_dir_next = decoded_dir;
            dir_time_next = s1_now_reg;
        end
    end

    // Commit the debounce state only as the transaction moves on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_button_reg <= 1'b0;
            button_time_reg <= '0;
            held_dir_reg    <= DIR_CENTER;
            dir_time_reg    <= '0;
        end
        else if (s1_advance)
        begin
            held_button_reg <= held_button_next;
            button_time_reg <= button_time_next;
            held_dir_reg    <= held_dir_next;
            dir_time_reg    <= dir_time_next;
        end
    end

    // Result register: hold while the consumer stalls.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_space)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_dir_reg     <= held_dir_next;
            out_changed_reg <= dir_take;
            out_press_reg   <= button_take && s1_button_reg;
            out_level_reg   <= s1_button_reg;
        end
    end

    assign out_valid         = out_valid_reg;
    assign direction         = out_dir_reg;
    assign direction_changed = out_changed_reg;
    assign press_event       = out_press_reg;
    assign button_level      = out_level_reg;

endmodule

`default_nettype wire

/* rtl/jdd_checker.sv */
// Port-level checker for the joystick direction debouncer and its bind.
// Depends on jdd_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module jdd_checker
    import jdd_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   in_valid,
    input  wire logic                   in_ready,
    input  wire logic [SAMPLE_BITS-1:0] x_sample,
    input  wire logic [SAMPLE_BITS-1:0] y_sample,
    input  wire logic                   button_down,
    input  wire logic [TIME_W-1:0]      now_ms,
    input  wire logic                   out_valid,
    input  wire logic                   out_ready,
    input  wire logic [2:0]             direction,
    input  wire logic                   direction_changed,
    input  wire logic                   press_event,
    input  wire logic                   button_level
);

    logic       in_acc;
    logic       out_acc;
    logic [1:0] pending_reg;
    logic [1:0] pending_next;
    logic [2:0] last_dir_reg;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (in_acc && !out_acc)
        begin
            pending_next = pending_reg + 2'd1;
        end
        else if (out_acc && !in_acc)
        begin
            pending_next = pending_reg - 2'd1;
        end
    end

    // Track transactions in flight and the last delivered direction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg  <= 2'd0;
            last_dir_reg <= DIR_CENTER;
        end
        else
        begin
            pending_reg <= pending_next;
            if (out_acc)
            begin
                last_dir_reg <= direction;
            end
        end
    end

    `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(direction) && $stable(press_event), "stalled result changed")
    `ASSERT_IMPLIES(a_no_orphan, out_valid, pending_reg != 2'd0 && pending_reg != 2'd3, "result without a matching input")
    `ASSERT_IMPLIES(a_press_level, out_valid && press_event, button_level, "press event with button released")
    `ASSERT_IMPLIES(a_change_flag, out_valid, direction_changed == (direction != last_dir_reg), "change flag disagrees with direction")

    wire unused_ok = cfg_we ^ (^cfg_index) ^ (^cfg_data) ^ (^x_sample) ^ (^y_sample)
                   ^ button_down ^ (^now_ms);

    `ASSERT_ALWAYS(a_unused_known, unused_ok == unused_ok, "unknown value on inputs")

endmodule

bind joystick_direction_debouncer_top jdd_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_jdd_checker (.*);

`default_nettype wire
